>>> design/hdst_pkg.sv
package hdst_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_SOURCES = 16;
  localparam int MIN_WIDTH   = 3;
  localparam int FP_FRAC     = 14;
  localparam int FP_HALF     = 1 << (FP_FRAC - 1);

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 10;
  localparam int ADDR_W    = COL_W + 1;
  localparam int DATA_W    = 16;
  localparam int SRC_IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int PADDR_W   = 5;
  localparam int CMP_W     = 12;

  localparam logic [10:0] GRID_WIDTH_RST    = 11'd64;
  localparam logic [9:0]  REGION_X0_RST     = 10'd1;
  localparam logic [9:0]  REGION_Y0_RST     = 10'd1;
  localparam logic [10:0] REGION_WIDTH_RST  = 11'd64;
  localparam logic [10:0] REGION_HEIGHT_RST = 11'd64;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH,
    REG_REGION_X0,
    REG_REGION_Y0,
    REG_REGION_WIDTH,
    REG_REGION_HEIGHT,
    REG_COEFF_X,
    REG_COEFF_Y,
    REG_SOURCE_COUNT
  } reg_idx_t;

  typedef enum logic {
    CMD_LOAD_SOURCE = 1'b0,
    CMD_SAMPLE      = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        [10:0] grid_width;
    logic        [9:0]  region_x0;
    logic        [9:0]  region_y0;
    logic        [10:0] region_width;
    logic        [10:0] region_height;
    logic signed [15:0] coeff_x;
    logic signed [15:0] coeff_y;
    logic        [4:0]  source_count;
  } cfg_t;

  typedef struct packed {
    logic        [9:0]  cx;
    logic        [9:0]  cy;
    logic               is_src;
    logic signed [15:0] down;
  } issue_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] up;
    logic [ADDR_W-1:0] right;
    logic [ADDR_W-1:0] left;
  } rd_addr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] cur;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] right;
    logic signed [DATA_W-1:0] left;
  } rd_data_t;

endpackage

>>> design/hdst_ram.sv
module hdst_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> design/hdst_cfg.sv
module hdst_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hdst_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output hdst_pkg::cfg_t               cfg
);

  hdst_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = hdst_pkg::reg_idx_t'(paddr[hdst_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width    <= hdst_pkg::GRID_WIDTH_RST;
      cfg.region_x0     <= hdst_pkg::REGION_X0_RST;
      cfg.region_y0     <= hdst_pkg::REGION_Y0_RST;
      cfg.region_width  <= hdst_pkg::REGION_WIDTH_RST;
      cfg.region_height <= hdst_pkg::REGION_HEIGHT_RST;
      cfg.coeff_x       <= '0;
      cfg.coeff_y       <= '0;
      cfg.source_count  <= '0;
    end else if (wr) begin
      case (idx)
        hdst_pkg::REG_GRID_WIDTH:    cfg.grid_width    <= pwdata[10:0];
        hdst_pkg::REG_REGION_X0:     cfg.region_x0     <= pwdata[9:0];
        hdst_pkg::REG_REGION_Y0:     cfg.region_y0     <= pwdata[9:0];
        hdst_pkg::REG_REGION_WIDTH:  cfg.region_width  <= pwdata[10:0];
        hdst_pkg::REG_REGION_HEIGHT: cfg.region_height <= pwdata[10:0];
        hdst_pkg::REG_COEFF_X:       cfg.coeff_x       <= pwdata[15:0];
        hdst_pkg::REG_COEFF_Y:       cfg.coeff_y       <= pwdata[15:0];
        hdst_pkg::REG_SOURCE_COUNT:  cfg.source_count  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      hdst_pkg::REG_GRID_WIDTH:    prdata = {21'b0, cfg.grid_width};
      hdst_pkg::REG_REGION_X0:     prdata = {22'b0, cfg.region_x0};
      hdst_pkg::REG_REGION_Y0:     prdata = {22'b0, cfg.region_y0};
      hdst_pkg::REG_REGION_WIDTH:  prdata = {21'b0, cfg.region_width};
      hdst_pkg::REG_REGION_HEIGHT: prdata = {21'b0, cfg.region_height};
      hdst_pkg::REG_COEFF_X:       prdata = {16'b0, cfg.coeff_x};
      hdst_pkg::REG_COEFF_Y:       prdata = {16'b0, cfg.coeff_y};
      hdst_pkg::REG_SOURCE_COUNT:  prdata = {27'b0, cfg.source_count};
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> design/hdst_front.sv
module hdst_front (
  input  logic                                clk,
  input  logic                                rst,
  input  hdst_pkg::cfg_t                      cfg,
  input  logic                                accept,
  input  logic                                command,
  input  logic signed [15:0]                  sample,
  input  logic                                frame_start,
  input  logic [3:0]                          source_index,
  input  logic [9:0]                          source_x,
  input  logic [9:0]                          source_y,
  output hdst_pkg::rd_addr_t                  rd_addr,
  output logic                                wr_en,
  output logic [hdst_pkg::ADDR_W-1:0]         wr_addr,
  output logic                                fire,
  output hdst_pkg::issue_t                    issue
);

  logic [hdst_pkg::COL_W-1:0]  column_count;
  logic [hdst_pkg::ROW_W-1:0]  row_count;
  logic [hdst_pkg::COL_W-1:0]  column_count_next;
  logic [hdst_pkg::ROW_W-1:0]  row_count_next;

  logic [9:0] src_x [hdst_pkg::MAX_SOURCES];
  logic [9:0] src_y [hdst_pkg::MAX_SOURCES];

  logic [hdst_pkg::ADDR_W-1:0] w;
  logic [hdst_pkg::ADDR_W-1:0] x_ext;
  logic [hdst_pkg::ADDR_W-1:0] new_base;
  logic [hdst_pkg::ADDR_W-1:0] cur_base;
  logic [hdst_pkg::ADDR_W-1:0] col_inc;
  logic [hdst_pkg::COL_W-1:0]  x;
  logic [hdst_pkg::ROW_W-1:0]  y;
  logic [9:0]                  cy;
  logic [hdst_pkg::CMP_W-1:0]  x_c;
  logic [hdst_pkg::CMP_W-1:0]  y_c;
  logic                        emit;
  logic                        hit;
  logic                        is_sample;
  int                          gw;

  assign is_sample = (hdst_pkg::cmd_t'(command) == hdst_pkg::CMD_SAMPLE);

  always_comb begin
    gw = int'(cfg.grid_width);
    if (gw < hdst_pkg::MIN_WIDTH) begin
      gw = hdst_pkg::MIN_WIDTH;
    end else if (gw > hdst_pkg::MAX_WIDTH) begin
      gw = hdst_pkg::MAX_WIDTH;
    end
    w = hdst_pkg::ADDR_W'(gw);

    if (frame_start) begin
      x = '0;
      y = '0;
    end else if (hdst_pkg::ADDR_W'(column_count) >= w) begin
      x = '0;
      y = row_count + 1'b1;
    end else begin
      x = column_count;
      y = row_count;
    end

    x_ext    = hdst_pkg::ADDR_W'(x);
    new_base = y[0] ? w : '0;
    cur_base = y[0] ? '0 : w;

    rd_addr.cur = cur_base + x_ext;
    rd_addr.up  = new_base + x_ext;
    if (x_ext + 1'b1 < w) begin
      rd_addr.right = cur_base + x_ext + 1'b1;
    end else begin
      rd_addr.right = new_base;
    end
    if (x != '0) begin
      rd_addr.left = cur_base + x_ext - 1'b1;
    end else begin
      rd_addr.left = new_base + w - 1'b1;
    end

    x_c  = hdst_pkg::CMP_W'(x);
    y_c  = hdst_pkg::CMP_W'(y);
    emit = (y != '0) &&
           (x_c >= hdst_pkg::CMP_W'(cfg.region_x0)) &&
           (x_c + 2'd2 < hdst_pkg::CMP_W'(cfg.region_x0) +
                         hdst_pkg::CMP_W'(cfg.region_width)) &&
           (y_c >= hdst_pkg::CMP_W'(cfg.region_y0) + 1'b1) &&
           (y_c + 1'b1 < hdst_pkg::CMP_W'(cfg.region_y0) +
                         hdst_pkg::CMP_W'(cfg.region_height));

    cy = 10'(y - 1'b1);

    hit = 1'b0;
    for (int i = 0; i < hdst_pkg::MAX_SOURCES; i++) begin
      if (i < int'(cfg.source_count) && src_x[i] == 10'(x) && src_y[i] == cy) begin
        hit = 1'b1;
      end
    end

    col_inc = x_ext + 1'b1;
    if (col_inc >= w) begin
      column_count_next = '0;
      row_count_next    = y + 1'b1;
    end else begin
      column_count_next = col_inc[hdst_pkg::COL_W-1:0];
      row_count_next    = y;
    end

    issue.cx     = 10'(x);
    issue.cy     = cy;
    issue.is_src = hit;
    issue.down   = sample;
  end

  assign wr_en   = accept && is_sample;
  assign wr_addr = rd_addr.up;
  assign fire    = accept && is_sample && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && is_sample) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_sample && int'(source_index) < hdst_pkg::MAX_SOURCES) begin
      src_x[source_index[hdst_pkg::SRC_IDX_W-1:0]] <= source_x;
      src_y[source_index[hdst_pkg::SRC_IDX_W-1:0]] <= source_y;
    end
  end

endmodule

>>> design/hdst_datapath.sv
module hdst_datapath (
  input  logic               clk,
  input  logic               rst,
  input  hdst_pkg::cfg_t     cfg,
  input  logic               fire,
  input  hdst_pkg::issue_t   issue,
  input  hdst_pkg::rd_data_t rd_data,
  output logic               ready,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [9:0]         cell_x,
  output logic [9:0]         cell_y,
  output logic signed [15:0] new_value
);

  logic s1_valid, s2_valid, s3_valid;
  logic s1_free, s2_free, s3_free, s4_free;

  hdst_pkg::issue_t   s1_meta;

  logic signed [15:0] s2_lap, s2_vert, s2_cur;
  logic               s2_is_src;
  logic [9:0]         s2_cx, s2_cy;

  logic signed [31:0] s3_prod_x, s3_prod_y;
  logic signed [15:0] s3_cur;
  logic               s3_is_src;
  logic [9:0]         s3_cx, s3_cy;

  logic signed [15:0] lap, vert;
  logic        [31:0] rnd_x, rnd_y;
  logic signed [15:0] fx_x, fx_y, sum;

  assign s4_free = !res_valid || !res_stall;
  assign s3_free = !s3_valid || s4_free;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign ready   = s1_free;

  assign lap  = rd_data.left + rd_data.right - (rd_data.cur <<< 1);
  assign vert = rd_data.up + s1_meta.down - (rd_data.cur <<< 1);

  always_comb begin
    rnd_x = s3_prod_x + 32'(hdst_pkg::FP_HALF);
    rnd_y = s3_prod_y + 32'(hdst_pkg::FP_HALF);
    fx_x  = rnd_x[hdst_pkg::FP_FRAC+15:hdst_pkg::FP_FRAC];
    fx_y  = rnd_y[hdst_pkg::FP_FRAC+15:hdst_pkg::FP_FRAC];
    sum   = s3_cur + fx_x + fx_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= fire;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (s4_free) res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_meta <= issue;
    end
    if (s2_free) begin
      s2_lap    <= lap;
      s2_vert   <= vert;
      s2_cur    <= rd_data.cur;
      s2_is_src <= s1_meta.is_src;
      s2_cx     <= s1_meta.cx;
      s2_cy     <= s1_meta.cy;
    end
    if (s3_free) begin
      s3_prod_x <= cfg.coeff_x * s2_lap;
      s3_prod_y <= cfg.coeff_y * s2_vert;
      s3_cur    <= s2_cur;
      s3_is_src <= s2_is_src;
      s3_cx     <= s2_cx;
      s3_cy     <= s2_cy;
    end
    if (s4_free) begin
      cell_x    <= s3_cx;
      cell_y    <= s3_cy;
      new_value <= s3_is_src ? s3_cur : sum;
    end
  end

endmodule

>>> design/heat_diffusion_stencil_q2_14.sv
// A sample that updates a cell gives its result through the s1, s2, s3 and output
// registers, when the output is free; a transfer without a result, or a source load,
// gives none. One command is taken every cycle unless stalled; the two line store copies
// each read two neighbors per cycle and take the sample write in the same cycle.
// Reset clears the position counters and the pipeline; the line stores and the heat
// source table hold undefined data until written, and no clearing pass is run.
module heat_diffusion_stencil_q2_14 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hdst_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic                         command,
  input  logic signed [15:0]           sample,
  input  logic                         frame_start,
  input  logic [3:0]                   source_index,
  input  logic [9:0]                   source_x,
  input  logic [9:0]                   source_y,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [9:0]                   cell_x,
  output logic [9:0]                   cell_y,
  output logic signed [15:0]           new_value
);

  hdst_pkg::cfg_t              cfg;
  hdst_pkg::rd_addr_t          rd_addr;
  hdst_pkg::rd_data_t          rd_data;
  hdst_pkg::issue_t            issue;
  logic                        wr_en;
  logic [hdst_pkg::ADDR_W-1:0] wr_addr;
  logic                        fire;
  logic                        dp_ready;
  logic                        accept;

  assign accept    = cmd_valid && dp_ready;
  assign cmd_stall = !dp_ready;

  hdst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hdst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .command      (command),
    .sample       (sample),
    .frame_start  (frame_start),
    .source_index (source_index),
    .source_x     (source_x),
    .source_y     (source_y),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .fire         (fire),
    .issue        (issue)
  );

  hdst_ram #(
    .ADDR_W (hdst_pkg::ADDR_W),
    .DATA_W (hdst_pkg::DATA_W)
  ) u_ram_a (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (sample),
    .re      (fire),
    .raddr_a (rd_addr.cur),
    .raddr_b (rd_addr.up),
    .rdata_a (rd_data.cur),
    .rdata_b (rd_data.up)
  );

  hdst_ram #(
    .ADDR_W (hdst_pkg::ADDR_W),
    .DATA_W (hdst_pkg::DATA_W)
  ) u_ram_b (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (sample),
    .re      (fire),
    .raddr_a (rd_addr.right),
    .raddr_b (rd_addr.left),
    .rdata_a (rd_data.right),
    .rdata_b (rd_data.left)
  );

  hdst_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .issue     (issue),
    .rd_data   (rd_data),
    .ready     (dp_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .new_value (new_value)
  );

endmodule

>>> design/hdst_checker.sv
module hdst_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic [9:0]         cell_x,
  input logic [9:0]         cell_y,
  input logic signed [15:0] new_value
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(cell_x) && $stable(cell_y) &&
                               $stable(new_value))
    else $error("Result changed or dropped while stalled.");

  // The input side only backs up when the whole pipeline is full behind a blocked result.
  a_stall_cause: assert property (@(posedge clk)
    cmd_stall |-> res_valid && res_stall)
    else $error("Input stalled while the result side was free.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_stall)
    else $error("Pipeline not empty after reset.");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !cmd_stall)
    else $error("Input stalled with no result pending.");

endmodule

bind heat_diffusion_stencil_q2_14 hdst_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .cell_x    (cell_x),
  .cell_y    (cell_y),
  .new_value (new_value)
);

>>> tb/tb.sv
module tb;
  import hdst_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int DIR_ROWS       = 40;
  localparam int SEND_PCT [4]   = '{0, 86, 0, 9};
  localparam int RECV_PCT [4]   = '{0, 0, 86, 9};

  typedef struct packed {
    logic        [9:0]  cell_x;
    logic        [9:0]  cell_y;
    logic signed [15:0] new_value;
  } cell_result_t;

  typedef enum logic [1:0] {DIR_REG, DIR_LOAD, DIR_SAMPLE} dir_kind_t;

  // a: register or source index, b: value, sample or source column, c: frame start or row.
  typedef struct {
    dir_kind_t kind;
    int        a;
    int        b;
    int        c;
    bit        typed;
    int        ex;
    int        ey;
    int        ev;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic                command = 1'b0;
  logic signed [15:0]  sample = '0;
  logic                frame_start = 1'b0;
  logic [3:0]          source_index = '0;
  logic [9:0]          source_x = '0;
  logic [9:0]          source_y = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [9:0]          cell_x;
  logic [9:0]          cell_y;
  logic signed [15:0]  new_value;

  heat_diffusion_stencil_q2_14 DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .sample       (sample),
    .frame_start  (frame_start),
    .source_index (source_index),
    .source_x     (source_x),
    .source_y     (source_y),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .new_value    (new_value)
  );

  cfg_t               shadow_cfg = '{grid_width: GRID_WIDTH_RST, region_x0: REGION_X0_RST,
                                     region_y0: REGION_Y0_RST, region_width: REGION_WIDTH_RST,
                                     region_height: REGION_HEIGHT_RST, default: '0};
  logic signed [15:0] line_mem [2*MAX_WIDTH];
  logic        [9:0]  src_col [MAX_SOURCES];
  logic        [9:0]  src_row [MAX_SOURCES];
  int                 col_pos = 0;
  int                 row_pos = 0;
  cell_result_t       pending_cells [$];
  int                 error_count = 0;
  int                 idle_cycles = 0;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{DIR_REG, REG_GRID_WIDTH, 3, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_REGION_WIDTH, 3, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_REGION_HEIGHT, 3, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_REGION_X0, 1, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_REGION_Y0, 1, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_COEFF_X, 0, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_COEFF_Y, 0, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_SOURCE_COUNT, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -32768, 1, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 5, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -1, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 1, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 100, 0, 1, 1, 1, 32767},
    '{DIR_SAMPLE, 0, 2, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_COEFF_X, 32767, 0, 0, 0, 0, 0},
    '{DIR_REG, REG_COEFF_Y, -32768, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 1, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -32768, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -32768, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -32768, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -32768, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 32767, 0, 0, 0, 0, 0},
    '{DIR_LOAD, 0, 1, 1, 0, 0, 0, 0},
    '{DIR_LOAD, 15, 1023, 1023, 0, 0, 0, 0},
    '{DIR_REG, REG_SOURCE_COUNT, 1, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 1, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, -32768, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{DIR_SAMPLE, 0, 7, 0, 1, 1, 1, -32768},
    '{DIR_SAMPLE, 0, 0, 0, 0, 0, 0, 0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] q_scale(int coeff, int delta);
    int prod;
    prod = coeff * delta + FP_HALF;
    return prod[29:14];
  endfunction

  function automatic bit diffuse_step(cmd_t c, logic [15:0] s, logic fs, logic [3:0] idx,
                                      logic [9:0] sx, logic [9:0] sy, output cell_result_t r);
    int w, x, y, half_new, half_cur, cur, up, right, left, x0, y0, rw, rh, nsrc, cxs, cys;
    logic signed [15:0] lap, vert, acc;
    bit emit, hit;
    r = '0;
    if (c == CMD_LOAD_SOURCE) begin
      src_col[idx] = sx;
      src_row[idx] = sy;
      return 1'b0;
    end
    w = shadow_cfg.grid_width;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (fs) begin
      x = 0;
      y = 0;
    end else begin
      x = col_pos;
      y = row_pos;
      if (x >= w) begin
        x = 0;
        y = (y + 1) & 1023;
      end
    end
    half_new = (y & 1) * w;
    half_cur = ((y + 1) & 1) * w;
    cur = line_mem[half_cur + x];
    up = line_mem[half_new + x];
    right = (x + 1 < w) ? line_mem[half_cur + x + 1] : line_mem[half_new];
    left = (x > 0) ? line_mem[half_cur + x - 1] : line_mem[half_new + w - 1];
    line_mem[half_new + x] = s;
    x0 = shadow_cfg.region_x0;
    y0 = shadow_cfg.region_y0;
    rw = shadow_cfg.region_width;
    rh = shadow_cfg.region_height;
    emit = (y >= 1) && (x >= x0) && (x < x0 + rw - 2) && (y - 1 >= y0) && (y - 1 < y0 + rh - 2);
    col_pos = x + 1;
    row_pos = y;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (y + 1) & 1023;
    end
    if (!emit) return 1'b0;
    nsrc = (shadow_cfg.source_count < MAX_SOURCES) ? shadow_cfg.source_count : MAX_SOURCES;
    hit = 1'b0;
    for (int i = 0; i < nsrc; i++) begin
      if (src_col[i] == x && src_row[i] == y - 1) hit = 1'b1;
    end
    if (hit) begin
      acc = cur;
    end else begin
      cxs = shadow_cfg.coeff_x;
      cys = shadow_cfg.coeff_y;
      lap = left + right - 2 * cur;
      vert = up + s - 2 * cur;
      acc = cur + q_scale(cxs, lap);
      acc = acc + q_scale(cys, vert);
    end
    r.cell_x = x;
    r.cell_y = y - 1;
    r.new_value = acc;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic int pick_extent(int hi);
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 2);
      1: return MAX_WIDTH;
      default: return $urandom_range(3, hi);
    endcase
  endfunction

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_GRID_WIDTH:    shadow_cfg.grid_width = v[10:0];
      REG_REGION_X0:     shadow_cfg.region_x0 = v[9:0];
      REG_REGION_Y0:     shadow_cfg.region_y0 = v[9:0];
      REG_REGION_WIDTH:  shadow_cfg.region_width = v[10:0];
      REG_REGION_HEIGHT: shadow_cfg.region_height = v[10:0];
      REG_COEFF_X:       shadow_cfg.coeff_x = v[15:0];
      REG_COEFF_Y:       shadow_cfg.coeff_y = v[15:0];
      default:           shadow_cfg.source_count = v[4:0];
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic push_item(cmd_t c, logic [15:0] s, logic fs, logic [3:0] idx,
                           logic [9:0] sx, logic [9:0] sy, bit typed_on, cell_result_t typed);
    cell_result_t pred;
    bit emit;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    command = c;
    sample = s;
    frame_start = fs;
    source_index = idx;
    source_x = sx;
    source_y = sy;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    emit = diffuse_step(c, s, fs, idx, sx, sy, pred);
    if (typed_on) pending_cells.push_back(typed);
    else if (emit) pending_cells.push_back(pred);
    @(negedge clk);
  endtask

  task automatic send_sample(logic [15:0] s, logic fs);
    push_item(CMD_SAMPLE, s, fs, $urandom_range(0, 15), $urandom_range(0, 1023),
              $urandom_range(0, 1023), 1'b0, '0);
  endtask

  task automatic send_load(logic [3:0] idx, logic [9:0] sx, logic [9:0] sy);
    push_item(CMD_LOAD_SOURCE, $urandom_range(0, 16'hFFFF), $urandom_range(0, 1), idx, sx, sy,
              1'b0, '0);
  endtask

  task automatic wait_idle();
    cmd_valid = 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) res_stall = ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_cells.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result x=%0d y=%0d value=%0d", $time, cell_x, cell_y,
                 new_value);
      end else begin
        want = pending_cells.pop_front();
        if (cell_x !== want.cell_x || cell_y !== want.cell_y ||
            new_value !== want.new_value) begin
          error_count++;
          $display("%0t: mismatch, expected x=%0d y=%0d value=%0d, actual x=%0d y=%0d value=%0d",
                   $time, want.cell_x, want.cell_y, want.new_value, cell_x, cell_y, new_value);
        end
      end
    end
  end

  // The run is stuck when neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int w, weff, x0, y0, rows, total, cut, phase, sent;
    cell_result_t typed_res;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Every line store slot and source entry is written before anything can read it.
    write_reg(REG_GRID_WIDTH, MAX_WIDTH);
    write_reg(REG_REGION_WIDTH, 0);
    for (int i = 0; i < MAX_SOURCES; i++) begin
      send_load(i, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
    for (int i = 0; i < 2 * MAX_WIDTH; i++) send_sample(pick_sample(), i == 0);

    foreach (dir_table[i]) begin
      case (dir_table[i].kind)
        DIR_REG: begin
          wait_idle();
          write_reg(reg_idx_t'(dir_table[i].a), dir_table[i].b);
        end
        DIR_LOAD: begin
          send_load(dir_table[i].a, dir_table[i].b, dir_table[i].c);
        end
        default: begin
          typed_res.cell_x = dir_table[i].ex;
          typed_res.cell_y = dir_table[i].ey;
          typed_res.new_value = dir_table[i].ev;
          push_item(CMD_SAMPLE, dir_table[i].b, dir_table[i].c, '0, '0, '0,
                    dir_table[i].typed, typed_res);
        end
      endcase
    end

    // Widest grid, with the region reaching the last column.
    wait_idle();
    write_reg(REG_GRID_WIDTH, 2047);
    write_reg(REG_REGION_X0, 1000);
    write_reg(REG_REGION_Y0, 1);
    write_reg(REG_REGION_WIDTH, 26);
    write_reg(REG_REGION_HEIGHT, 3);
    write_reg(REG_COEFF_X, pick_coeff());
    write_reg(REG_COEFF_Y, pick_coeff());
    write_reg(REG_SOURCE_COUNT, 31);
    for (int i = 0; i < 3 * MAX_WIDTH; i++) send_sample(pick_sample(), i == 0);

    // Narrowest grid, long enough for the row counter to wrap.
    wait_idle();
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_REGION_X0, 1);
    write_reg(REG_REGION_Y0, 1020);
    write_reg(REG_REGION_WIDTH, 3);
    write_reg(REG_REGION_HEIGHT, 5);
    write_reg(REG_SOURCE_COUNT, 0);
    for (int i = 0; i < 3 * 1027; i++) send_sample(pick_sample(), i == 0);

    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      phase = (phase + 1) % 4;
      send_gap_pct = SEND_PCT[phase];
      recv_stall_pct = RECV_PCT[phase];
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      weff = (w < MIN_WIDTH) ? MIN_WIDTH : w;
      x0 = $urandom_range(1, weff);
      y0 = $urandom_range(1, 3);
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_REGION_X0, x0);
      write_reg(REG_REGION_Y0, y0);
      write_reg(REG_REGION_WIDTH, pick_extent(weff + 1));
      write_reg(REG_REGION_HEIGHT, pick_extent(6));
      write_reg(REG_COEFF_X, pick_coeff());
      write_reg(REG_COEFF_Y, pick_coeff());
      write_reg(REG_SOURCE_COUNT, ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(0, 17));
      repeat ($urandom_range(0, 3)) begin
        send_load($urandom_range(0, 15),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : x0 + $urandom_range(0, 2),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : y0 + $urandom_range(0, 2));
        sent++;
      end
      rows = $urandom_range(3, 7);
      total = weff * rows;
      cut = (weff > MIN_WIDTH && $urandom_range(0, 5) == 0) ? $urandom_range(weff + 1, total - 1)
                                                           : -1;
      for (int k = 0; k < total; k++) begin
        if (k == cut) begin
          wait_idle();
          write_reg(REG_GRID_WIDTH, $urandom_range(MIN_WIDTH, weff - 1));
        end
        if ($urandom_range(0, 29) == 0) begin
          send_load($urandom_range(0, 15), $urandom_range(0, 1023), $urandom_range(0, 1023));
          sent++;
        end
        send_sample(pick_sample(), (k == 0) || ($urandom_range(0, 299) == 0));
        sent++;
      end
    end

    cmd_valid = 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
